// ===== src/glpm_pkg.sv =====
// shared constants and types for the glob pattern list matcher
package glpm_pkg;

  localparam int PATTERN_CHARS = 32;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 64;
  localparam int NUM_WORDS     = 4;
  localparam int PAT_W         = NUM_WORDS * WORD_W;
  localparam int WSEL_W        = $clog2(NUM_WORDS);
  localparam int LEN_W         = 6;
  localparam int POS_W         = $clog2(PATTERN_CHARS + 1);
  localparam int IDX_W         = 3;

  localparam logic [IDX_W-1:0] REG_LENGTH = 3'd4;

  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_ANY  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_SEP  = 8'h3B;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic              fresh;
    logic              step;
    logic [BYTE_W-1:0] ch;
  } ctrl_t;

  // what one cell hands to the cell after it
  typedef struct packed {
    logic close;
    logic adv;
    logic sep;
  } link_t;

endpackage

// ===== src/glpm_cell.sv =====
// one pattern position: holds its alive bit and links to the next position
module glpm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  glpm_pkg::ctrl_t            ctrl,
  input  logic [glpm_pkg::BYTE_W-1:0] pat,
  input  logic                       in_range,
  input  logic                       at_end,
  input  logic                       first,
  input  glpm_pkg::link_t            prev,
  output glpm_pkg::link_t            nxt,
  output logic                       hit
);

  logic raw;
  logic raw_next;
  logic start_raw;
  logic cur;
  logic is_star;
  logic is_sep;

  always_comb begin
    is_star   = (pat == glpm_pkg::CH_STAR);
    is_sep    = (pat == glpm_pkg::CH_SEP);
    // a segment starts at position 0 and after a separator inside the length
    start_raw = first | (prev.sep & in_range);
    // star closure ripples in from the left neighbor
    cur       = (ctrl.fresh ? start_raw : raw) | prev.close;
    nxt.close = cur & in_range & is_star;
    nxt.adv   = cur & in_range & ~is_star & ~is_sep &
                ((pat == glpm_pkg::CH_ANY) | (pat == ctrl.ch));
    nxt.sep   = is_sep;
    hit       = cur & (at_end | (in_range & is_sep));
    raw_next  = ctrl.step ? (nxt.close | prev.adv) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw <= 1'b0;
    end else begin
      raw <= raw_next;
    end
  end

endmodule

// ===== src/glpm_chain.sv =====
// row of position cells plus the end-of-pattern position
module glpm_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  glpm_pkg::ctrl_t             ctrl,
  input  logic [glpm_pkg::PAT_W-1:0]  pattern,
  input  logic [glpm_pkg::POS_W-1:0]  len_eff,
  output logic                        hit
);

  glpm_pkg::link_t                        links [glpm_pkg::PATTERN_CHARS+1];
  logic [glpm_pkg::PATTERN_CHARS-1:0]     cell_hit;
  logic                                   tail;
  logic                                   tail_next;
  logic                                   tail_cur;

  assign links[0] = '0;

  for (genvar p = 0; p < glpm_pkg::PATTERN_CHARS; p++) begin : g_cell
    glpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .pat      (pattern[p*glpm_pkg::BYTE_W +: glpm_pkg::BYTE_W]),
      .in_range (glpm_pkg::POS_W'(p) < len_eff),
      .at_end   (glpm_pkg::POS_W'(p) == len_eff),
      .first    (p == 0),
      .prev     (links[p]),
      .nxt      (links[p+1]),
      .hit      (cell_hit[p])
    );
  end

  // last position past the final byte: only reachable at full length
  always_comb begin
    tail_cur  = (ctrl.fresh ? 1'b0 : tail) | links[glpm_pkg::PATTERN_CHARS].close;
    tail_next = ctrl.step ? links[glpm_pkg::PATTERN_CHARS].adv : tail;
    hit       = (|cell_hit) | tail_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 1'b0;
    end else begin
      tail <= tail_next;
    end
  end

endmodule

// ===== src/glob_pattern_list_matcher_unit.sv =====
// an end-of-name word gives its result in the cycle after it is accepted
// throughput: one word per cycle when not stalled; the cell row steps on each byte
// input stalls only while a result waits and the output side stalls
// reset (synchronous): pattern and length cleared, match state restarts, no result held
// top level of the glob pattern list matcher
module glob_pattern_list_matcher_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [glpm_pkg::BYTE_W-1:0]  name_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         matched,
  input  logic                         wr_en,
  input  logic [glpm_pkg::IDX_W-1:0]   wr_index,
  input  logic [glpm_pkg::WORD_W-1:0]  wr_data
);

  logic [glpm_pkg::PAT_W-1:0]  pattern;
  logic [glpm_pkg::LEN_W-1:0]  len;
  logic [glpm_pkg::POS_W-1:0]  len_eff;
  logic                        fresh;
  logic                        in_acc;
  logic                        byte_acc;
  logic                        end_acc;
  logic                        cfg_hit;
  logic                        hit;
  glpm_pkg::ctrl_t             ctrl;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign byte_acc = in_acc & (opcode == glpm_pkg::OP_BYTE);
  assign end_acc  = in_acc & (opcode == glpm_pkg::OP_END);
  assign cfg_hit  = wr_en & (wr_index <= glpm_pkg::REG_LENGTH);

  assign len_eff = (len > glpm_pkg::LEN_W'(glpm_pkg::PATTERN_CHARS)) ?
                   glpm_pkg::POS_W'(glpm_pkg::PATTERN_CHARS) :
                   glpm_pkg::POS_W'(len);

  assign ctrl.fresh = fresh;
  assign ctrl.step  = byte_acc;
  assign ctrl.ch    = name_byte;

  glpm_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .pattern (pattern),
    .len_eff (len_eff),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern   <= '0;
      len       <= '0;
      fresh     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (wr_en && wr_index < glpm_pkg::REG_LENGTH) begin
        pattern[wr_index[glpm_pkg::WSEL_W-1:0]*glpm_pkg::WORD_W +: glpm_pkg::WORD_W] <= wr_data;
      end
      if (wr_en && wr_index == glpm_pkg::REG_LENGTH) begin
        len <= wr_data[glpm_pkg::LEN_W-1:0];
      end
      // fresh: active set is the closed segment-start set of the current pattern
      priority if (cfg_hit) begin
        fresh <= 1'b1;
      end else if (end_acc) begin
        fresh <= 1'b1;
      end else if (byte_acc) begin
        fresh <= 1'b0;
      end
      if (end_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_acc) begin
      matched <= hit;
    end
  end

endmodule

// ===== src/glpm_checker.sv =====
// port-level checks for the glob pattern list matcher, bound to the top level
module glpm_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         opcode,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         matched
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched))
    else $error("result changed while stalled");

  // an end-of-name word always yields a result next cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == glpm_pkg::OP_END |=> out_valid)
    else $error("end of name gave no result");

  // a name byte never yields a result
  a_byte_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == glpm_pkg::OP_BYTE |=> !out_valid)
    else $error("name byte gave a result");

  // input is held back only by a waiting, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind glob_pattern_list_matcher_unit glpm_port_checks u_glpm_port_checks (.*);

// ===== dv/glpm_checker.sv =====
// checker for the glob pattern list matcher: predicts each match bit and compares
module glpm_checker
  import glpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] name_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              matched,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [WORD_W-1:0] wr_data,
  output int                results_due,
  output int                mismatches
);

  logic [WORD_W-1:0]      pat_words [NUM_WORDS];
  logic [LEN_W-1:0]       pat_len;
  logic [PATTERN_CHARS:0] alive;
  logic                   match_due [$];
  logic                   due_bit;

  function automatic int used_len();
    return (pat_len > PATTERN_CHARS) ? PATTERN_CHARS : int'(pat_len);
  endfunction

  function automatic logic [BYTE_W-1:0] pat_at(int i);
    return pat_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // a live star also makes the position after it live
  function automatic logic [PATTERN_CHARS:0] star_close(logic [PATTERN_CHARS:0] s);
    for (int p = 0; p < used_len(); p++)
      if (s[p] && pat_at(p) == CH_STAR) s[p+1] = 1'b1;
    return s;
  endfunction

  function automatic logic [PATTERN_CHARS:0] segment_starts();
    logic [PATTERN_CHARS:0] s;
    s = '0;
    s[0] = 1'b1;
    for (int p = 0; p < used_len(); p++)
      if (pat_at(p) == CH_SEP && p + 1 < used_len()) s[p+1] = 1'b1;
    return star_close(s);
  endfunction

  function automatic logic [PATTERN_CHARS:0] advance(logic [BYTE_W-1:0] c);
    logic [PATTERN_CHARS:0] nxt;
    logic [BYTE_W-1:0]      pc;
    nxt = '0;
    for (int p = 0; p < used_len(); p++) begin
      pc = pat_at(p);
      if (alive[p] && pc != CH_SEP) begin
        if (pc == CH_STAR) nxt[p] = 1'b1;
        else if (pc == CH_ANY || pc == c) nxt[p+1] = 1'b1;
      end
    end
    return star_close(nxt);
  endfunction

  // some live position sits at a segment end
  function automatic logic segment_done();
    logic hit;
    hit = alive[used_len()];
    for (int p = 0; p < used_len(); p++)
      if (alive[p] && pat_at(p) == CH_SEP) hit = 1'b1;
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) pat_words[i] = '0;
      pat_len = '0;
      alive = segment_starts();
      match_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (match_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with no word pending: expected none, actual matched=%0b",
                   $time, matched);
        end else begin
          due_bit = match_due.pop_front();
          if (matched !== due_bit) begin
            mismatches++;
            $display("%0t: matched mismatch: expected %0b, actual %0b",
                     $time, due_bit, matched);
          end
        end
      end
      if (wr_en && wr_index <= REG_LENGTH) begin
        if (wr_index < REG_LENGTH) pat_words[wr_index[WSEL_W-1:0]] = wr_data;
        else pat_len = wr_data[LEN_W-1:0];
        alive = segment_starts();
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_BYTE) begin
          alive = advance(name_byte);
        end else begin
          match_due.push_back(segment_done());
          alive = segment_starts();
        end
      end
    end
    results_due <= match_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the glob pattern list matcher: stimulus, idling and verdict
module tb_top;
  import glpm_pkg::*;

  localparam logic [IDX_W-1:0] REG_BYTES_LOW = 3'd0;
  localparam int               RANDOM_ITEMS  = 1100;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              opcode;
  logic [BYTE_W-1:0] name_byte;
  logic              out_valid;
  logic              out_stall;
  logic              matched;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [WORD_W-1:0] wr_data;
  int                results_due;
  int                mismatches;

  logic [WORD_W-1:0] cfg_words [NUM_WORDS];
  logic [LEN_W-1:0]  cfg_len;
  logic [BYTE_W-1:0] name_q [$];
  int                items_sent;
  int                phase;
  bit                fast_send;
  bit                fast_recv;
  bit                hold_long;

  glob_pattern_list_matcher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .name_byte (name_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  glpm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .name_byte   (name_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .matched     (matched),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  // biased toward pattern metacharacters and edge bytes
  function automatic logic [BYTE_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2:       return "b";
      3:       return CH_STAR;
      4:       return CH_ANY;
      5:       return CH_SEP;
      6:       return 8'h00;
      7:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] cfg_char(int i);
    return cfg_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    name_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_item(OP_BYTE, name_q[i]);
    send_item(OP_END, BYTE_W'($urandom_range(0, 255)));
  endtask

  // pause the sender until every match bit is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    if (idx < REG_LENGTH) cfg_words[idx[WSEL_W-1:0]] = data;
    else if (idx == REG_LENGTH) cfg_len = data[LEN_W-1:0];
  endtask

  task automatic new_pattern();
    logic [WORD_W-1:0] w [NUM_WORDS];
    logic [LEN_W-1:0]  len;
    int                first;
    int                idx;
    for (int k = 0; k < NUM_WORDS; k++) begin
      case ($urandom_range(0, 7))
        0:       w[k] = '0;
        1:       w[k] = '1;
        2:       w[k] = {8{CH_STAR}};
        default: for (int b = 0; b < 8; b++) w[k][b*8 +: 8] = pick_char();
      endcase
    end
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = LEN_W'(PATTERN_CHARS);
      2:       len = LEN_W'($urandom_range(PATTERN_CHARS + 1, 63));
      3:       len = LEN_W'($urandom_range(13, PATTERN_CHARS - 1));
      default: len = LEN_W'($urandom_range(1, 12));
    endcase
    first = $urandom_range(0, NUM_WORDS);
    for (int k = 0; k <= NUM_WORDS; k++) begin
      idx = (first + k) % (NUM_WORDS + 1);
      if (idx == REG_LENGTH)
        write_reg(REG_LENGTH,
                  (WORD_W'({$urandom, $urandom}) & ~WORD_W'(63)) | WORD_W'(len));
      else
        write_reg(IDX_W'(idx), w[idx]);
    end
    // index past the last register is dropped
    if ($urandom_range(0, 3) == 0)
      write_reg(IDX_W'($urandom_range(REG_LENGTH + 1, 7)), {$urandom, $urandom});
    wr_en <= 1'b0;
  endtask

  task automatic build_name();
    int                starts [$];
    int                eff;
    int                p;
    int                k;
    int                kind;
    logic [BYTE_W-1:0] c;
    name_q.delete();
    kind = $urandom_range(0, 9);
    eff = (cfg_len > PATTERN_CHARS) ? PATTERN_CHARS : int'(cfg_len);
    if (kind < 6) begin
      // walk one alternative, filling wildcards with random bytes
      starts.push_back(0);
      for (p = 0; p < eff; p++)
        if (cfg_char(p) == CH_SEP && p + 1 < eff) starts.push_back(p + 1);
      p = starts[$urandom_range(0, starts.size() - 1)];
      while (p < eff && cfg_char(p) != CH_SEP) begin
        c = cfg_char(p);
        if (c == CH_STAR) repeat ($urandom_range(0, 3)) name_q.push_back(pick_char());
        else if (c == CH_ANY) name_q.push_back(pick_char());
        else name_q.push_back(c);
        p++;
      end
      if (kind == 5) begin
        if (name_q.size() > 0 && $urandom_range(0, 1) == 0) begin
          k = $urandom_range(0, name_q.size() - 1);
          name_q[k] = name_q[k] ^ (8'h01 << $urandom_range(0, 7));
        end else begin
          name_q.push_back(pick_char());
        end
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(0, 6)) name_q.push_back(pick_char());
    end else begin
      repeat ($urandom_range(20, 40)) name_q.push_back(pick_char());
    end
  endtask

  // receiver: random stall per word, one long hold-off on request
  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        hold = 80;
        hold_long = 1'b0;
      end else begin
        hold = fast_recv ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_BYTE;
    name_byte <= '0;
    wr_en     <= 1'b0;
    wr_index  <= '0;
    wr_data   <= '0;
    for (int i = 0; i < NUM_WORDS; i++) cfg_words[i] = '0;
    cfg_len    = '0;
    items_sent = 0;
    phase      = 0;
    fast_send  = 1'b0;
    fast_recv  = 1'b0;
    hold_long  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // cleared pattern: only the empty name matches
    name_q.delete();
    send_name();
    name_q = '{8'h00};
    send_name();
    drain();

    // alternatives "a?*", empty, "?" then a zero byte, trailing separator
    write_reg(REG_BYTES_LOW,
              {CH_SEP, 8'h00, CH_ANY, CH_SEP, CH_SEP, CH_STAR, CH_ANY, 8'h61});
    write_reg(REG_LENGTH, 64'd8);
    write_reg(IDX_W'($urandom_range(REG_LENGTH + 1, 7)), '1);
    wr_en <= 1'b0;
    name_q.delete();
    send_name();
    name_q = '{8'h61, 8'h62};
    send_name();
    name_q = '{8'h61};
    send_name();
    name_q = '{CH_SEP, 8'h00};
    send_name();
    name_q = '{8'h61, 8'hFF, CH_SEP, 8'h80};
    send_name();
    name_q = '{8'h62, 8'h00, 8'h00};
    send_name();

    while (items_sent < RANDOM_ITEMS) begin
      // leave a name half done so the register write has to restart it
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_item(OP_BYTE, pick_char());
      drain();
      fast_send = ($urandom_range(0, 3) == 0);
      fast_recv = ($urandom_range(0, 3) == 0);
      new_pattern();
      if (phase == 2) begin
        // back-to-back end words against a long output hold-off
        hold_long = 1'b1;
        fast_send = 1'b1;
        repeat (16) begin
          name_q.delete();
          send_name();
        end
        fast_send = 1'b0;
      end
      repeat ($urandom_range(6, 18)) begin
        build_name();
        send_name();
      end
      phase++;
    end

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/glpm_pkg.sv
src/glpm_cell.sv
src/glpm_chain.sv
src/glob_pattern_list_matcher_unit.sv
src/glpm_checker.sv
dv/glpm_checker.sv
dv/tb_top.sv
